[hdl/y2r_pkg.sv]
// ----------------------------------------------------------------------------
// y2r_pkg
// shared types and constants of the 4:2:0 to rgb converter
// ----------------------------------------------------------------------------
package y2r_pkg;

  // widths of counters, sizes and samples
  localparam int unsigned CNT_W  = 12;
  localparam int unsigned SIZE_W = 14;
  localparam int unsigned CFG_W  = 13;
  localparam int unsigned PIX_W  = 8;

  // line count limit of the frame
  localparam logic [SIZE_W-1:0] MAX_HEIGHT = 14'd4096;

  // configuration register indexes
  typedef enum logic [0:0] {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_idx_e;

  // bt.601 full range coefficients, q16
  localparam logic signed [17:0] K_RV = 18'sd91881;
  localparam logic signed [17:0] K_GU = 18'sd22553;
  localparam logic signed [17:0] K_GV = 18'sd46802;
  localparam logic signed [17:0] K_BU = 18'sd116130;

  // product and sum widths
  localparam int unsigned PROD_W = 26;
  localparam int unsigned SUM_W  = 28;

  // middle queue
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = 2;
  localparam int unsigned QCNT_W = 3;

  // effective frame size
  typedef struct packed {
    logic [SIZE_W-1:0] width;
    logic [SIZE_W-1:0] height;
  } geom_t;

  // one classified pixel with its resolved chroma pair
  typedef struct packed {
    logic [PIX_W-1:0] luma;
    logic [PIX_W-1:0] cb;
    logic [PIX_W-1:0] cr;
    logic             line_end;
    logic             frame_end;
  } pix_t;

endpackage

[hdl/y2r_front.sv]
// ----------------------------------------------------------------------------
// y2r_front
// raster counters, chroma line buffer and chroma pair selection
// ----------------------------------------------------------------------------
module y2r_front #(
  parameter int unsigned MAX_WIDTH = 4096
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  y2r_pkg::geom_t                geom_i,
  input  logic                          push_i,
  input  logic [y2r_pkg::PIX_W-1:0]     luma_i,
  input  logic [y2r_pkg::PIX_W-1:0]     cb_i,
  input  logic [y2r_pkg::PIX_W-1:0]     cr_i,
  output logic                          ready_o,
  output logic                          out_valid_o,
  output y2r_pkg::pix_t                 out_pix_o,
  input  logic                          out_ready_i
);

  localparam int unsigned Slots = MAX_WIDTH / 2;
  localparam int unsigned IdxW  = (Slots > 1) ? $clog2(Slots) : 1;
  localparam logic [IdxW-1:0] LastSlot = IdxW'(Slots - 1);
  localparam int unsigned CntW  = y2r_pkg::CNT_W;
  localparam int unsigned SizeW = y2r_pkg::SIZE_W;

  logic [CntW-1:0]  col_q, col_d, row_q, row_d;
  logic [IdxW-1:0]  slot_q, slot_d;
  logic [15:0]      held_q;
  logic [CntW:0]    col_inc, row_inc;
  logic             accept, line_end, frame_end, even_row, even_col, wr_en;
  logic [15:0]      new_pair, pair_even;

  logic             s1_v_q;
  logic [7:0]       s1_luma_q;
  logic [15:0]      s1_pair_q;
  logic             s1_odd_q, s1_le_q, s1_fe_q;
  logic [15:0]      rd_q;
  logic [15:0]      line_mem [Slots];
  logic [15:0]      pair;

  assign ready_o     = !s1_v_q || out_ready_i;
  assign accept      = push_i && ready_o;
  assign out_valid_o = s1_v_q;

  assign col_inc   = {1'b0, col_q} + 1'b1;
  assign row_inc   = {1'b0, row_q} + 1'b1;
  assign line_end  = SizeW'(col_inc) >= geom_i.width;
  assign frame_end = line_end && (SizeW'(row_inc) >= geom_i.height);

  assign even_row  = !row_q[0];
  assign even_col  = !col_q[0];
  assign wr_en     = accept && even_row && even_col;
  assign new_pair  = {cb_i, cr_i};
  assign pair_even = even_col ? new_pair : held_q;

  // next raster position; slot tracks (column / 2) modulo the buffer depth
  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    slot_d = slot_q;
    if (line_end) begin
      col_d  = '0;
      slot_d = '0;
      row_d  = frame_end ? '0 : row_inc[CntW-1:0];
    end else begin
      col_d = col_inc[CntW-1:0];
      if (col_d == '0) begin
        slot_d = '0;
      end else if (!col_d[0]) begin
        slot_d = (slot_q == LastSlot) ? '0 : slot_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      slot_q <= '0;
      held_q <= '0;
      s1_v_q <= 1'b0;
    end else begin
      if (accept) begin
        col_q  <= col_d;
        row_q  <= row_d;
        slot_q <= slot_d;
        s1_v_q <= 1'b1;
      end else if (out_ready_i) begin
        s1_v_q <= 1'b0;
      end
      if (wr_en) begin
        held_q <= new_pair;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_luma_q <= luma_i;
      s1_pair_q <= pair_even;
      s1_odd_q  <= !even_row;
      s1_le_q   <= line_end;
      s1_fe_q   <= frame_end;
    end
  end

  // half-width chroma line buffer
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      line_mem[slot_q] <= new_pair;
    end
    if (accept) begin
      rd_q <= line_mem[slot_q];
    end
  end

  assign pair = s1_odd_q ? rd_q : s1_pair_q;

  always_comb begin
    out_pix_o.luma      = s1_luma_q;
    out_pix_o.cb        = pair[15:8];
    out_pix_o.cr        = pair[7:0];
    out_pix_o.line_end  = s1_le_q;
    out_pix_o.frame_end = s1_fe_q;
  end

  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_q <= LastSlot)
    else $error("line buffer slot out of range");

  a_line_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && line_end |=> col_q == '0 && slot_q == '0)
    else $error("column did not wrap at line end");

  a_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_v_q && !out_ready_i |=> s1_v_q && $stable(s1_luma_q) && $stable(s1_le_q))
    else $error("stalled front stage lost its pixel");

endmodule

[hdl/y2r_queue.sv]
// ----------------------------------------------------------------------------
// y2r_queue
// short pixel queue between front and back
// ----------------------------------------------------------------------------
module y2r_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  y2r_pkg::pix_t in_pix_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  output y2r_pkg::pix_t out_pix_o,
  input  logic          out_ready_i
);

  localparam int unsigned PtrW = y2r_pkg::QPTR_W;
  localparam int unsigned CntW = y2r_pkg::QCNT_W;
  localparam logic [CntW-1:0] Depth = CntW'(y2r_pkg::QDEPTH);

  y2r_pkg::pix_t       store_q [y2r_pkg::QDEPTH];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]     count_q;
  logic                do_push, do_pop;

  assign in_ready_o  = count_q != Depth;
  assign out_valid_o = count_q != '0;
  assign do_push     = in_valid_i && in_ready_o;
  assign do_pop      = out_valid_o && out_ready_i;
  assign out_pix_o   = store_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_ptr_q] <= in_pix_i;
    end
  end

  // pointer distance matches the count modulo the depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= Depth && count_q[PtrW-1:0] == wr_ptr_q - rd_ptr_q)
    else $error("queue count and pointers disagree");

endmodule

[hdl/y2r_back.sv]
// ----------------------------------------------------------------------------
// y2r_back
// color matrix multiply, sum, clamp and result register
// ----------------------------------------------------------------------------
module y2r_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  y2r_pkg::pix_t             in_pix_i,
  output logic                      in_ready_o,
  output logic                      out_valid_o,
  output logic [y2r_pkg::PIX_W-1:0] red_o,
  output logic [y2r_pkg::PIX_W-1:0] green_o,
  output logic [y2r_pkg::PIX_W-1:0] blue_o,
  output logic                      line_end_o,
  output logic                      frame_end_o,
  input  logic                      out_ready_i
);

  localparam int unsigned PrW = y2r_pkg::PROD_W;
  localparam int unsigned SmW = y2r_pkg::SUM_W;
  localparam logic signed [PrW-1:0] KRv = PrW'(y2r_pkg::K_RV);
  localparam logic signed [PrW-1:0] KGu = PrW'(y2r_pkg::K_GU);
  localparam logic signed [PrW-1:0] KGv = PrW'(y2r_pkg::K_GV);
  localparam logic signed [PrW-1:0] KBu = PrW'(y2r_pkg::K_BU);

  // negative sum gives 0, else drop the q16 fraction and saturate at 255
  function automatic logic [7:0] to_chan(input logic signed [SmW-1:0] s);
    logic [7:0] res;
    if (s < 0) begin
      res = '0;
    end else if (s[SmW-2:16] > 11'd255) begin
      res = 8'd255;
    end else begin
      res = s[23:16];
    end
    return res;
  endfunction

  logic                  m_v_q, o_v_q, m_ready, o_ready;
  logic signed [8:0]     u_s, v_s;
  logic signed [PrW-1:0] p_rv_q, p_gu_q, p_gv_q, p_bu_q;
  logic [7:0]            m_luma_q;
  logic                  m_le_q, m_fe_q;
  logic signed [SmW-1:0] y_s, r_sum, g_sum, b_sum;

  assign o_ready    = !o_v_q || out_ready_i;
  assign m_ready    = !m_v_q || o_ready;
  assign in_ready_o = m_ready;

  assign u_s = $signed({1'b0, in_pix_i.cb}) - 9'sd128;
  assign v_s = $signed({1'b0, in_pix_i.cr}) - 9'sd128;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_v_q <= 1'b0;
      o_v_q <= 1'b0;
    end else begin
      if (m_ready) begin
        m_v_q <= in_valid_i;
      end
      if (o_ready) begin
        o_v_q <= m_v_q;
      end
    end
  end

  // multiply stage
  always_ff @(posedge clk_i) begin
    if (m_ready && in_valid_i) begin
      p_rv_q   <= KRv * PrW'(v_s);
      p_gu_q   <= KGu * PrW'(u_s);
      p_gv_q   <= KGv * PrW'(v_s);
      p_bu_q   <= KBu * PrW'(u_s);
      m_luma_q <= in_pix_i.luma;
      m_le_q   <= in_pix_i.line_end;
      m_fe_q   <= in_pix_i.frame_end;
    end
  end

  assign y_s   = $signed({4'b0, m_luma_q, 16'b0});
  assign r_sum = y_s + SmW'(p_rv_q);
  assign g_sum = y_s - SmW'(p_gu_q) - SmW'(p_gv_q);
  assign b_sum = y_s + SmW'(p_bu_q);

  // result register
  always_ff @(posedge clk_i) begin
    if (o_ready && m_v_q) begin
      red_o       <= to_chan(r_sum);
      green_o     <= to_chan(g_sum);
      blue_o      <= to_chan(b_sum);
      line_end_o  <= m_le_q;
      frame_end_o <= m_fe_q;
    end
  end

  assign out_valid_o = o_v_q;

endmodule

[hdl/yuv420_to_rgb_converter_top.sv]
// ----------------------------------------------------------------------------
// yuv420_to_rgb_converter_top
// 4:2:0 raster pixel stream to rgb, full range bt.601
// ----------------------------------------------------------------------------
// usage:
//   input side is a queue: drive a pixel beat with push high while full is
//   low. luma comes with every beat; chroma_blue/chroma_red are sampled only
//   at even rows and even columns and shared by each 2x2 block through a
//   half-width line buffer (MAX_WIDTH/2 entries, one write and one read
//   port) and a one-pair hold register.
//   result side is a queue: while empty is low the oldest rgb beat, with
//   its line_end and frame_end flags, sits on the ports; pop takes it.
//   one result beat per input beat, one beat per clock sustained while
//   pop keeps up. an accepted beat passes the front stage with the line
//   buffer read, the middle queue, the multiply stage and the clamp into
//   the result register before empty goes low. a 4-entry queue splits
//   front from back, and the result register accepts a new beat in the
//   same cycle as its old one is popped. a stalled receiver fills the
//   back stages and the queue, then raises full; nothing is dropped.
//   reset clears counters, hold pair and valid flags; size registers come
//   up at 640 x 480. the line buffer is not cleared: the first even line
//   of each frame fills it before odd lines read it. sizes must be written
//   through cfg_* only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module yuv420_to_rgb_converter_top #(
  parameter int unsigned MAX_WIDTH = 4096
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration write port
  input  logic                        cfg_we_i,
  input  logic [0:0]                  cfg_idx_i,
  input  logic [y2r_pkg::CFG_W-1:0]   cfg_wdata_i,
  // pixel input queue
  input  logic                        push,
  output logic                        full,
  input  logic [y2r_pkg::PIX_W-1:0]   luma_i,
  input  logic [y2r_pkg::PIX_W-1:0]   chroma_blue_i,
  input  logic [y2r_pkg::PIX_W-1:0]   chroma_red_i,
  // rgb result queue
  output logic                        empty,
  input  logic                        pop,
  output logic [y2r_pkg::PIX_W-1:0]   red_o,
  output logic [y2r_pkg::PIX_W-1:0]   green_o,
  output logic [y2r_pkg::PIX_W-1:0]   blue_o,
  output logic                        line_end_o,
  output logic                        frame_end_o
);

  localparam int unsigned SzW  = y2r_pkg::SIZE_W;
  localparam int unsigned CfgW = y2r_pkg::CFG_W;
  localparam logic [SzW-1:0] MaxW = SzW'(MAX_WIDTH);
  localparam logic [SzW-1:0] MinSize = SzW'(2);

  // size registers
  logic [CfgW-1:0]  width_q, height_q;
  logic [SzW-1:0]   width_even, height_even;
  y2r_pkg::geom_t   geom;

  // front -> queue -> back handshakes
  logic             front_ready, front_valid;
  y2r_pkg::pix_t    front_pix;
  logic             q_in_ready, q_out_valid, back_ready, back_valid;
  y2r_pkg::pix_t    q_pix;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 13'd640;
      height_q <= 13'd480;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        y2r_pkg::CFG_FRAME_WIDTH:  width_q  <= cfg_wdata_i;
        y2r_pkg::CFG_FRAME_HEIGHT: height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // effective sizes: low bit dropped, at least 2, width capped at the buffer limit, height at the line limit
  assign width_even  = {1'b0, width_q[CfgW-1:1], 1'b0};
  assign height_even = {1'b0, height_q[CfgW-1:1], 1'b0};

  always_comb begin
    priority if (width_even < MinSize) begin
      geom.width = MinSize;
    end else if (width_even > MaxW) begin
      geom.width = MaxW;
    end else begin
      geom.width = width_even;
    end
    priority if (height_even < MinSize) begin
      geom.height = MinSize;
    end else if (height_even > y2r_pkg::MAX_HEIGHT) begin
      geom.height = y2r_pkg::MAX_HEIGHT;
    end else begin
      geom.height = height_even;
    end
  end

  y2r_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .geom_i      (geom),
    .push_i      (push),
    .luma_i      (luma_i),
    .cb_i        (chroma_blue_i),
    .cr_i        (chroma_red_i),
    .ready_o     (front_ready),
    .out_valid_o (front_valid),
    .out_pix_o   (front_pix),
    .out_ready_i (q_in_ready)
  );

  assign full = !front_ready;

  y2r_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (front_valid),
    .in_pix_i    (front_pix),
    .in_ready_o  (q_in_ready),
    .out_valid_o (q_out_valid),
    .out_pix_o   (q_pix),
    .out_ready_i (back_ready)
  );

  y2r_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (q_out_valid),
    .in_pix_i    (q_pix),
    .in_ready_o  (back_ready),
    .out_valid_o (back_valid),
    .red_o       (red_o),
    .green_o     (green_o),
    .blue_o      (blue_o),
    .line_end_o  (line_end_o),
    .frame_end_o (frame_end_o),
    .out_ready_i (pop)
  );

  assign empty = !back_valid;

endmodule

[dv/yuv420_to_rgb_converter_top_tb.sv]
// ----------------------------------------------------------------------------
// yuv420_to_rgb_converter_top_tb
// self-checking bench for the 4:2:0 to rgb pixel converter
// ----------------------------------------------------------------------------
// a queue of pending yuv beats feeds a clocked driver; every accepted beat is
// run through a local model of the converter (counters, half-width chroma
// line, hold pair, q16 bt.601 math with clamps) and the rgb beat it gives is
// queued. a clocked monitor pops rgb beats and compares each field with the
// oldest queued beat. directed frames hit the sample extremes, odd and out of
// range size registers and size changes with the counters beyond the new
// size; then a long stretch of a line at the widest size and many small
// random frames follow.
// both sides idle at random, with one stall-free stretch and one long
// receiver hold-off that backs the block up until it raises full.
// ----------------------------------------------------------------------------
module yuv420_to_rgb_converter_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PixW = y2r_pkg::PIX_W;
  localparam int unsigned CfgW = y2r_pkg::CFG_W;

  // bench knobs
  localparam int unsigned LAT_CYCLES   = 8;     // settle time after the last beat
  localparam int unsigned ERR_SHOWN    = 10;    // mismatches printed in full
  localparam int unsigned IDLE_PCT     = 34;    // idle chance per cycle, percent
  localparam int unsigned HOLD_CYCLES  = 80;    // long receiver hold-off
  localparam int unsigned HOLD_AT      = 300;   // accepted beats before the hold-off
  localparam int unsigned BURST_LO     = 700;   // stall-free window, in accepted beats
  localparam int unsigned BURST_HI     = 1000;
  localparam int unsigned WIDE_ITEMS   = 400;   // beats sent at the widest size
  localparam int unsigned RANDOM_ITEMS = 850;

  // converter constants: line limit and q16 bt.601 coefficients
  localparam int unsigned LINE_MAX  = 4096;
  localparam int unsigned ROWS_MAX  = 4096;
  localparam longint      COEF_RV   = 91881;
  localparam longint      COEF_GU   = 22553;
  localparam longint      COEF_GV   = 46802;
  localparam longint      COEF_BU   = 116130;

  typedef struct packed {
    logic [PixW-1:0] luma;
    logic [PixW-1:0] cb;
    logic [PixW-1:0] cr;
  } yuv_beat_t;

  typedef struct packed {
    logic [PixW-1:0] red;
    logic [PixW-1:0] green;
    logic [PixW-1:0] blue;
    logic            line_end;
    logic            frame_end;
  } rgb_beat_t;

  // dut signals, all inputs known from time zero
  logic            clk_i         = 1'b0;
  logic            rst_ni        = 1'b0;
  logic            cfg_we_i      = 1'b0;
  logic [0:0]      cfg_idx_i     = '0;
  logic [CfgW-1:0] cfg_wdata_i   = '0;
  logic            push          = 1'b0;
  logic            full;
  logic [PixW-1:0] luma_i        = '0;
  logic [PixW-1:0] chroma_blue_i = '0;
  logic [PixW-1:0] chroma_red_i  = '0;
  logic            empty;
  logic            pop           = 1'b0;
  logic [PixW-1:0] red_o;
  logic [PixW-1:0] green_o;
  logic [PixW-1:0] blue_o;
  logic            line_end_o;
  logic            frame_end_o;

  // stimulus and expected rgb beats
  yuv_beat_t   pending_q[$];
  rgb_beat_t   rgb_expect_q[$];
  rgb_beat_t   rgb_want;
  int unsigned accepted_cnt = 0;
  int unsigned err_cnt      = 0;
  logic        rx_hold      = 1'b0;

  // local copy of the converter state and size registers
  logic [CfgW-1:0] width_reg  = 13'd640;
  logic [CfgW-1:0] height_reg = 13'd480;
  int unsigned     col_cnt    = 0;
  int unsigned     row_cnt    = 0;
  logic [15:0]     held_pair  = '0;
  logic [15:0]     chroma_mem [LINE_MAX/2];

  yuv420_to_rgb_converter_top #(
    .MAX_WIDTH (LINE_MAX)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .push          (push),
    .full          (full),
    .luma_i        (luma_i),
    .chroma_blue_i (chroma_blue_i),
    .chroma_red_i  (chroma_red_i),
    .empty         (empty),
    .pop           (pop),
    .red_o         (red_o),
    .green_o       (green_o),
    .blue_o        (blue_o),
    .line_end_o    (line_end_o),
    .frame_end_o   (frame_end_o)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // size register to effective size: low bit dropped, at least 2, capped
  function automatic int unsigned eff_size(logic [CfgW-1:0] reg_val,
                                           int unsigned cap);
    int unsigned v;
    v = reg_val & 13'h1FFE;
    if (v < 2) v = 2;
    if (v > cap) v = cap;
    return v;
  endfunction

  // q16 sum to a channel: negative gives 0, fraction truncated, saturate at 255
  function automatic logic [PixW-1:0] q16_to_chan(longint acc);
    if (acc < 0) return '0;
    if ((acc >>> 16) > 255) return 8'd255;
    return acc[23:16];
  endfunction

  // no idling on either side inside the burst window
  function automatic bit take_gap();
    if (accepted_cnt >= BURST_LO && accepted_cnt < BURST_HI) return 1'b0;
    return $urandom_range(0, 99) < IDLE_PCT;
  endfunction

  // one accepted yuv beat -> expected rgb beat, advances the local state
  task automatic convert_pixel(input yuv_beat_t px);
    int unsigned w_eff;
    int unsigned h_eff;
    int unsigned slot;
    logic [15:0] pair;
    longint      y_q;
    longint      u_c;
    longint      v_c;
    rgb_beat_t   res;
    w_eff = eff_size(width_reg, LINE_MAX);
    h_eff = eff_size(height_reg, ROWS_MAX);
    slot  = col_cnt >> 1;
    // even rows take chroma at even columns and fill the line; odd rows replay it
    if (row_cnt % 2 == 0) begin
      if (col_cnt % 2 == 0) begin
        held_pair        = {px.cb, px.cr};
        chroma_mem[slot] = held_pair;
      end
      pair = held_pair;
    end else begin
      pair = chroma_mem[slot];
    end
    y_q = longint'(px.luma) * 65536;
    u_c = longint'(pair[15:8]) - 128;
    v_c = longint'(pair[7:0]) - 128;
    res.red       = q16_to_chan(y_q + COEF_RV * v_c);
    res.green     = q16_to_chan(y_q - COEF_GU * u_c - COEF_GV * v_c);
    res.blue      = q16_to_chan(y_q + COEF_BU * u_c);
    res.line_end  = (col_cnt + 1 >= w_eff);
    res.frame_end = res.line_end && (row_cnt + 1 >= h_eff);
    rgb_expect_q.push_back(res);
    // counters wrap as soon as they reach the size, even one that just shrank
    if (res.line_end) begin
      col_cnt = 0;
      row_cnt = res.frame_end ? 0 : ((row_cnt + 1) & 12'hFFF);
    end else begin
      col_cnt = (col_cnt + 1) & 12'hFFF;
    end
  endtask

  // driver: counts the accepted beat, then offers the next one or idles
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push          <= 1'b0;
      luma_i        <= '0;
      chroma_blue_i <= '0;
      chroma_red_i  <= '0;
    end else begin
      if (push && !full) begin
        convert_pixel({luma_i, chroma_blue_i, chroma_red_i});
        void'(pending_q.pop_front());
        accepted_cnt++;
      end
      if (pending_q.size() != 0 && !take_gap()) begin
        push          <= 1'b1;
        luma_i        <= pending_q[0].luma;
        chroma_blue_i <= pending_q[0].cb;
        chroma_red_i  <= pending_q[0].cr;
      end else begin
        // idle beat: junk on the data lines must be ignored
        push          <= 1'b0;
        luma_i        <= PixW'($urandom);
        chroma_blue_i <= PixW'($urandom);
        chroma_red_i  <= PixW'($urandom);
      end
    end
  end

  // monitor: checks the popped rgb beat against the oldest expectation
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (rgb_expect_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= ERR_SHOWN)
            $display("%0t: rgb beat with nothing expected: r=%0d g=%0d b=%0d le=%0b fe=%0b",
                     $time, red_o, green_o, blue_o, line_end_o, frame_end_o);
        end else begin
          rgb_want = rgb_expect_q.pop_front();
          if (red_o !== rgb_want.red || green_o !== rgb_want.green ||
              blue_o !== rgb_want.blue || line_end_o !== rgb_want.line_end ||
              frame_end_o !== rgb_want.frame_end) begin
            err_cnt++;
            if (err_cnt <= ERR_SHOWN) begin
              $display("%0t: rgb mismatch, exp r=%0d g=%0d b=%0d le=%0b fe=%0b",
                       $time, rgb_want.red, rgb_want.green, rgb_want.blue,
                       rgb_want.line_end, rgb_want.frame_end);
              $display("%0t: rgb mismatch, got r=%0d g=%0d b=%0d le=%0b fe=%0b",
                       $time, red_o, green_o, blue_o, line_end_o, frame_end_o);
            end
          end
        end
      end
      pop <= !rx_hold && !take_gap();
    end
  end

  // receiver hold-off, counted here while the sender keeps offering
  initial begin
    while (accepted_cnt < HOLD_AT) @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  // hard limit, far beyond the slowest correct run
  initial begin
    #1_000_000;
    $display("yuv420_to_rgb_converter_top_tb: FAIL");
    $finish;
  end

  task automatic write_reg(input y2r_pkg::cfg_idx_e idx, input logic [CfgW-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == y2r_pkg::CFG_FRAME_WIDTH) width_reg = val;
    else height_reg = val;
  endtask

  task automatic queue_pixel(input logic [PixW-1:0] y, input logic [PixW-1:0] cb,
                             input logic [PixW-1:0] cr);
    pending_q.push_back('{luma: y, cb: cb, cr: cr});
  endtask

  task automatic queue_random(input int unsigned n);
    repeat (n) queue_pixel(PixW'($urandom), PixW'($urandom), PixW'($urandom));
  endtask

  // every beat sent and checked, then the pipe is left to settle
  task automatic wait_idle();
    while (pending_q.size() != 0 || rgb_expect_q.size() != 0) @(posedge clk_i);
    repeat (LAT_CYCLES) @(posedge clk_i);
  endtask

  // stimulus
  initial begin
    int unsigned     w;
    int unsigned     h;
    int unsigned     n;
    int unsigned     rand_items;
    logic [CfgW-1:0] w_val;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // 2x2 frames from size values below the minimum
    write_reg(y2r_pkg::CFG_FRAME_WIDTH, 13'd1);
    write_reg(y2r_pkg::CFG_FRAME_HEIGHT, 13'd0);
    // saturating chroma at top-left, ignored chroma elsewhere
    queue_pixel(8'd255, 8'd255, 8'd255);
    queue_pixel(8'd0,   8'd0,   8'd0);
    queue_pixel(8'd0,   8'h11,  8'h11);
    queue_pixel(8'd255, 8'd0,   8'd0);
    // zero chroma: red and blue clamp low at zero luma, green saturates high at full luma
    queue_pixel(8'd0,   8'd0,   8'd0);
    queue_pixel(8'd255, 8'd255, 8'd255);
    queue_pixel(8'd255, 8'h80,  8'h80);
    queue_pixel(8'd0,   8'hFF,  8'h00);
    wait_idle();

    // width shrinks below the current column on an even row
    write_reg(y2r_pkg::CFG_FRAME_WIDTH, 13'h1FFF);
    write_reg(y2r_pkg::CFG_FRAME_HEIGHT, 13'h1FFF);
    queue_random(6);
    wait_idle();
    write_reg(y2r_pkg::CFG_FRAME_WIDTH, 13'd5);
    write_reg(y2r_pkg::CFG_FRAME_HEIGHT, 13'd2);
    queue_random(5);
    wait_idle();

    // height shrinks below the current row
    write_reg(y2r_pkg::CFG_FRAME_WIDTH, 13'd2);
    write_reg(y2r_pkg::CFG_FRAME_HEIGHT, 13'd4);
    queue_random(5);
    wait_idle();
    write_reg(y2r_pkg::CFG_FRAME_HEIGHT, 13'd3);
    queue_random(1);
    wait_idle();

    // long stretch of a line at the widest size; the hold-off lands here
    write_reg(y2r_pkg::CFG_FRAME_WIDTH, 13'd4096);
    write_reg(y2r_pkg::CFG_FRAME_HEIGHT, 13'd2);
    queue_random(WIDE_ITEMS);
    wait_idle();
    // narrow width ends the even line at once, then a short odd line replays it
    write_reg(y2r_pkg::CFG_FRAME_WIDTH, 13'd4);
    queue_random(5);
    wait_idle();

    // small random frames, whole frames per setting; the burst lands here
    rand_items = 0;
    while (rand_items < RANDOM_ITEMS) begin
      w     = 2 * $urandom_range(1, 16);
      h     = 2 * $urandom_range(1, 3);
      w_val = CfgW'(w) | CfgW'($urandom_range(0, 1));
      if (w == 2 && $urandom_range(0, 1) == 1) w_val = CfgW'($urandom_range(0, 1));
      write_reg(y2r_pkg::CFG_FRAME_WIDTH, w_val);
      write_reg(y2r_pkg::CFG_FRAME_HEIGHT, CfgW'(h) | CfgW'($urandom_range(0, 1)));
      n = w * h * $urandom_range(1, 2);
      queue_random(n);
      rand_items += n;
      wait_idle();
    end

    if (err_cnt == 0) begin
      $display("yuv420_to_rgb_converter_top_tb: PASS");
    end else begin
      $display("yuv420_to_rgb_converter_top_tb: FAIL");
    end
    $finish;
  end

endmodule
